/* src/efr_pkg.sv */
`timescale 1ns / 1ps
package efr_pkg;

    localparam int KIND_W   = 2;
    localparam int INDEX_W  = 6;
    localparam int LENGTH_W = 7;
    localparam int CAP_W    = 7;

    localparam logic [KIND_W-1:0] KIND_BYTE     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EMPTY    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_OVERFLOW = 2'd2;

    localparam int REG_IDX_W = 2;
    localparam logic [REG_IDX_W-1:0] REG_START_FLAG  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_END_FLAG    = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_ESCAPE_FLAG = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_CAPACITY    = 2'd3;

    localparam logic [7:0]       START_FLAG_RESET  = 8'd126;
    localparam logic [7:0]       END_FLAG_RESET    = 8'd127;
    localparam logic [7:0]       ESCAPE_FLAG_RESET = 8'd128;
    localparam logic [CAP_W-1:0] CAPACITY_RESET    = 7'd64;

    typedef struct packed {
        logic [7:0]       start_flag;
        logic [7:0]       end_flag;
        logic [7:0]       escape_flag;
        logic [CAP_W-1:0] capacity;
    } cfg_t;

    typedef struct packed {
        logic take;        // a link byte transfers this cycle
        logic begin_read;  // the byte releases a non-empty packet
        logic reading;     // packet readout in progress
    } cmd_t;

    typedef struct packed {
        logic release_nonempty; // current byte is an end flag with bytes stored
        logic out_hold;         // result register full and not taken
        logic read_done;        // final packet byte loads into the result register
    } status_t;

endpackage

/* src/efr_link_if.sv */
`timescale 1ns / 1ps
interface efr_link_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

/* src/efr_result_if.sv */
`timescale 1ns / 1ps
interface efr_result_if;
    logic                         valid;
    logic                         ready;
    logic [efr_pkg::KIND_W-1:0]   kind;
    logic [7:0]                   data_byte;
    logic [efr_pkg::INDEX_W-1:0]  byte_index;
    logic [efr_pkg::LENGTH_W-1:0] packet_length;
    logic                         last;

    modport source (output valid, output kind, output data_byte, output byte_index,
                    output packet_length, output last, input ready);
    modport sink (input valid, input kind, input data_byte, input byte_index,
                  input packet_length, input last, output ready);
endinterface

/* src/efr_ram.sv */
`timescale 1ns / 1ps
module efr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

/* src/efr_ctrl.sv */
`timescale 1ns / 1ps
module efr_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  efr_pkg::status_t status,
    output efr_pkg::cmd_t    cmd
);
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_READ = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   take;

    // accept link bytes only while idle and the result register can move
    assign in_ready = (state_reg == ST_IDLE) && !status.out_hold;
    assign take     = in_valid && in_ready;

    assign cmd.take       = take;
    assign cmd.begin_read = take && status.release_nonempty;
    assign cmd.reading    = (state_reg == ST_READ);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.begin_read)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (status.read_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end
endmodule

/* src/efr_datapath.sv */
`timescale 1ns / 1ps
module efr_datapath #(
    parameter int BUFFER_DEPTH = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  efr_pkg::cfg_t                cfg,
    input  efr_pkg::cmd_t                cmd,
    output efr_pkg::status_t             status,
    input  logic [7:0]                   rx_byte,
    input  logic                         res_ready,
    output logic                         res_valid,
    output logic [efr_pkg::KIND_W-1:0]   kind,
    output logic [7:0]                   data_byte,
    output logic [efr_pkg::INDEX_W-1:0]  byte_index,
    output logic [efr_pkg::LENGTH_W-1:0] packet_length,
    output logic                         last
);
    localparam int CW = $clog2(BUFFER_DEPTH + 1);
    localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam logic [efr_pkg::CAP_W-1:0] DEPTH_CAP = efr_pkg::CAP_W'(BUFFER_DEPTH);

    logic          esc_reg, esc_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic [CW-1:0] len_reg, len_next;
    logic [CW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [AW-1:0] rd_idx_reg, rd_idx_next;
    logic          rd_valid_reg, rd_valid_next;

    logic                         res_valid_reg, res_valid_next;
    logic [efr_pkg::KIND_W-1:0]   kind_reg, kind_next;
    logic [7:0]                   data_reg, data_next;
    logic [efr_pkg::INDEX_W-1:0]  index_reg, index_next;
    logic [efr_pkg::LENGTH_W-1:0] length_reg, length_next;
    logic                         last_reg, last_next;

    logic hit_start, hit_esc, hit_end, hit_data;
    logic [efr_pkg::CAP_W-1:0] cap_lim;
    logic overflow;
    logic ram_we, ram_re, load_out, slot_free, rd_last;
    logic [7:0] ram_rdata;

    // byte class: start, then escape, then end; anything else is data
    always_comb
    begin
        hit_start = !esc_reg && (rx_byte == cfg.start_flag);
        hit_esc   = !esc_reg && !hit_start && (rx_byte == cfg.escape_flag);
        hit_end   = !esc_reg && !hit_start && !hit_esc && (rx_byte == cfg.end_flag);
        hit_data  = !(hit_start || hit_esc || hit_end);
        cap_lim   = (cfg.capacity > DEPTH_CAP) ? DEPTH_CAP : cfg.capacity;
        overflow  = efr_pkg::CAP_W'(fill_reg) >= cap_lim;
    end

    assign slot_free = !res_valid_reg || res_ready;
    assign load_out  = cmd.reading && rd_valid_reg && slot_free;
    assign ram_re    = cmd.reading && (rd_ptr_reg < len_reg) && (!rd_valid_reg || load_out);
    assign ram_we    = cmd.take && hit_data && !overflow;
    assign rd_last   = (CW'(rd_idx_reg) + 1'b1) == len_reg;

    assign status.release_nonempty = hit_end && (fill_reg != '0);
    assign status.out_hold         = !slot_free;
    assign status.read_done        = load_out && rd_last;

    always_comb
    begin
        esc_next       = esc_reg;
        fill_next      = fill_reg;
        len_next       = len_reg;
        rd_ptr_next    = rd_ptr_reg;
        rd_idx_next    = rd_idx_reg;
        rd_valid_next  = rd_valid_reg;
        res_valid_next = res_ready ? 1'b0 : res_valid_reg;
        kind_next      = kind_reg;
        data_next      = data_reg;
        index_next     = index_reg;
        length_next    = length_reg;
        last_next      = last_reg;

        if (cmd.take)
        begin
            if (hit_esc)
            begin
                esc_next = 1'b1;
            end
            else if (hit_end)
            begin
                fill_next = '0;
                if (fill_reg == '0)
                begin
                    res_valid_next = 1'b1;
                    kind_next      = efr_pkg::KIND_EMPTY;
                    data_next      = '0;
                    index_next     = '0;
                    length_next    = '0;
                    last_next      = 1'b1;
                end
                else
                begin
                    len_next    = fill_reg;
                    rd_ptr_next = '0;
                end
            end
            else if (hit_data)
            begin
                esc_next = 1'b0;
                if (overflow)
                begin
                    res_valid_next = 1'b1;
                    kind_next      = efr_pkg::KIND_OVERFLOW;
                    data_next      = '0;
                    index_next     = '0;
                    length_next    = '0;
                    last_next      = 1'b1;
                end
                else
                begin
                    fill_next = CW'(fill_reg + 1'b1);
                end
            end
        end

        // readout: ram data register acts as a one-entry stage ahead of the result
        if (load_out)
        begin
            res_valid_next = 1'b1;
            kind_next      = efr_pkg::KIND_BYTE;
            data_next      = ram_rdata;
            index_next     = efr_pkg::INDEX_W'(rd_idx_reg);
            length_next    = efr_pkg::LENGTH_W'(len_reg);
            last_next      = rd_last;
            rd_valid_next  = 1'b0;
        end
        if (ram_re)
        begin
            rd_valid_next = 1'b1;
            rd_idx_next   = rd_ptr_reg[AW-1:0];
            rd_ptr_next   = CW'(rd_ptr_reg + 1'b1);
        end
    end

    efr_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (fill_reg[AW-1:0]),
        .wdata (rx_byte),
        .re    (ram_re),
        .raddr (rd_ptr_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_reg       <= 1'b0;
            fill_reg      <= '0;
            len_reg       <= '0;
            rd_ptr_reg    <= '0;
            rd_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            esc_reg       <= esc_next;
            fill_reg      <= fill_next;
            len_reg       <= len_next;
            rd_ptr_reg    <= rd_ptr_next;
            rd_valid_reg  <= rd_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= rd_idx_next;
        kind_reg   <= kind_next;
        data_reg   <= data_next;
        index_reg  <= index_next;
        length_reg <= length_next;
        last_reg   <= last_next;
    end

    assign res_valid     = res_valid_reg;
    assign kind          = kind_reg;
    assign data_byte     = data_reg;
    assign byte_index    = index_reg;
    assign packet_length = length_reg;
    assign last          = last_reg;
endmodule

/* src/escaped_frame_receiver.sv */
`timescale 1ns / 1ps
// Byte-stuffing deframer, receive side. Link bytes arrive on the link channel,
// one per transfer; results leave on the result channel, one per transfer.
// Start flags, escape flags and stored data bytes are accepted every cycle
// while no packet is read out and the result register can move. An overflow
// or an empty-packet release gives one result. An end flag that releases
// stored bytes holds off the link channel until the final stored byte loads
// into the result register: the packet store has one registered read port,
// read once per result byte. Any stall on the result channel lengthens that
// hold. The packet store needs no clearing after reset. Configuration registers
// sit on an APB port at byte addresses 0 (start flag), 4 (end flag), 8 (escape
// flag) and 12 (capacity); write them only while the block is idle.
module escaped_frame_receiver #(
    parameter int BUFFER_DEPTH = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    efr_link_if.sink             link,
    efr_result_if.source         result
);
    efr_pkg::cfg_t    cfg_reg;
    efr_pkg::cfg_t    cfg_next;
    efr_pkg::cmd_t    cmd;
    efr_pkg::status_t status;

    logic [efr_pkg::REG_IDX_W-1:0] reg_idx;
    logic                          cfg_write;

    // the APB port never waits
    assign pready    = 1'b1;
    assign reg_idx   = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;

    // register write decode; each register keeps only its own width
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (reg_idx)
                efr_pkg::REG_START_FLAG:  cfg_next.start_flag  = pwdata[7:0];
                efr_pkg::REG_END_FLAG:    cfg_next.end_flag    = pwdata[7:0];
                efr_pkg::REG_ESCAPE_FLAG: cfg_next.escape_flag = pwdata[7:0];
                efr_pkg::REG_CAPACITY:    cfg_next.capacity    = pwdata[efr_pkg::CAP_W-1:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    // read back the addressed register, zero-extended
    always_comb
    begin
        unique case (reg_idx)
            efr_pkg::REG_START_FLAG:  prdata = {24'd0, cfg_reg.start_flag};
            efr_pkg::REG_END_FLAG:    prdata = {24'd0, cfg_reg.end_flag};
            efr_pkg::REG_ESCAPE_FLAG: prdata = {24'd0, cfg_reg.escape_flag};
            efr_pkg::REG_CAPACITY:    prdata = 32'(cfg_reg.capacity);
            default: prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_flag  <= efr_pkg::START_FLAG_RESET;
            cfg_reg.end_flag    <= efr_pkg::END_FLAG_RESET;
            cfg_reg.escape_flag <= efr_pkg::ESCAPE_FLAG_RESET;
            cfg_reg.capacity    <= efr_pkg::CAPACITY_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // controller: gates link transfers and sequences the packet readout
    efr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (link.valid),
        .in_ready (link.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath: escape flag, fill count, packet store and result register
    efr_datapath #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .cmd           (cmd),
        .status        (status),
        .rx_byte       (link.rx_byte),
        .res_ready     (result.ready),
        .res_valid     (result.valid),
        .kind          (result.kind),
        .data_byte     (result.data_byte),
        .byte_index    (result.byte_index),
        .packet_length (result.packet_length),
        .last          (result.last)
    );
endmodule
